/* src/gsr_pkg.sv */
// Package for the Gardner timing recovery block: sizes, reset values,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package gsr_pkg;

  localparam int TAPS_DEF   = 17;
  localparam int PHASES_DEF = 4;

  localparam int SMP_W      = 16;
  localparam int COEF_W     = 18;
  localparam int CIDX_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXDEV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PGAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FGAIN  = 2'd3;

  localparam logic [29:0] CENTER_RST = 30'd134217728;
  localparam logic [28:0] MAXDEV_RST = 29'd524288;
  localparam logic [23:0] PGAIN_RST  = 24'd65536;
  localparam logic [23:0] FGAIN_RST  = 24'd256;

  localparam logic signed [31:0] Q29_ONE = 32'sh2000_0000;
  localparam logic signed [31:0] Q29_TWO = 32'sh4000_0000;

  // controller to datapath
  typedef struct packed {
    logic line_wr;
    logic coef_wr;
    logic add;
    logic clr;
    logic rd;
    logic mul;
    logic acc;
    logic rnd;
    logic mid_ld;
    logic err;
    logic gain;
    logic trm;
    logic upd;
    logic push;
    logic last;
    logic hold_ld;
  } gsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic slot;
    logic out_free;
    logic hold_v;
  } gsr_sts_t;

endpackage

/* src/gsr_if.sv */
// Stream interfaces: sample/coefficient input and recovered symbol output.
// Depends on gsr_pkg.
interface gsr_in_if import gsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [SMP_W-1:0]  sample_value;
  logic [CIDX_W-1:0]        coeff_index;
  logic signed [COEF_W-1:0] coeff_value;
  modport source (output valid, func, sample_value, coeff_index, coeff_value, input ready);
  modport sink   (input valid, func, sample_value, coeff_index, coeff_value, output ready);
endinterface

interface gsr_out_if import gsr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] symbol_value;
  logic                    last_of_run;
  modport source (output valid, symbol_value, last_of_run, input ready);
  modport sink   (input valid, symbol_value, last_of_run, output ready);
endinterface

/* src/gsr_datapath.sv */
// Datapath: delay line, coefficient memory, MAC, loop filter, symbol hold and output register.
// Depends on gsr_pkg; driven by gsr_ctrl.
module gsr_datapath import gsr_pkg::*; #(
  parameter int TAPS   = TAPS_DEF,
  parameter int PHASES = PHASES_DEF,
  localparam int BW    = (PHASES > 1) ? $clog2(PHASES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [SMP_W-1:0]  sample_i,
  input  logic [CIDX_W-1:0]        cidx_i,
  input  logic signed [COEF_W-1:0] cval_i,
  input  logic [BW-1:0]            bank_i,
  input  gsr_cmd_t                 cmd_i,
  output gsr_sts_t                 sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [SMP_W-1:0]  out_sym_o,
  output logic                     out_last_o
);

  localparam int NC    = PHASES * TAPS;
  localparam int LW    = $clog2(TAPS);
  localparam int CAW   = $clog2(NC);
  localparam int PW    = SMP_W + COEF_W;
  localparam int ACC_W = PW + $clog2(TAPS) + 1;
  localparam logic [CIDX_W:0] NC_L = (CIDX_W+1)'(NC);

  // configuration registers
  logic [29:0] ctr_q;
  logic [28:0] mfd_q;
  logic [23:0] pg_q, fg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= CENTER_RST;
      mfd_q <= MAXDEV_RST;
      pg_q  <= PGAIN_RST;
      fg_q  <= FGAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER: ctr_q <= cfg_data_i[29:0];
        CFG_MAXDEV: mfd_q <= cfg_data_i[28:0];
        CFG_PGAIN:  pg_q  <= cfg_data_i[23:0];
        CFG_FGAIN:  fg_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // delay line and write pointer
  logic signed [SMP_W-1:0] line_q [TAPS];
  logic [LW-1:0] wpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) line_q[i] <= '0;
      wpos_q <= '0;
    end else if (cmd_i.line_wr) begin
      line_q[wpos_q] <= sample_i;
      wpos_q <= (wpos_q == LW'(TAPS-1)) ? '0 : wpos_q + 1'b1;
    end
  end

  // coefficient memory, registered read
  logic signed [COEF_W-1:0] coef_m [NC];
  logic signed [COEF_W-1:0] cdat_q;
  logic signed [SMP_W-1:0]  sdat_q;
  logic [LW-1:0]  sp_q;
  logic [CAW-1:0] cp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && ({1'b0, cidx_i} < NC_L)) coef_m[cidx_i[CAW-1:0]] <= cval_i;
    if (cmd_i.rd) begin
      cdat_q <= coef_m[cp_q];
      sdat_q <= line_q[sp_q];
    end
  end

  // read pointers: oldest sample first, through the chosen bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      cp_q <= '0;
    end else if (cmd_i.clr) begin
      sp_q <= wpos_q;
      cp_q <= CAW'(int'(bank_i) * TAPS);
    end else if (cmd_i.rd) begin
      sp_q <= (sp_q == LW'(TAPS-1)) ? '0 : sp_q + 1'b1;
      cp_q <= cp_q + 1'b1;
    end
  end

  // multiply, then accumulate
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= sdat_q * cdat_q;
    if (cmd_i.clr) acc_q <= '0;
    else if (cmd_i.acc) acc_q <= acc_q + ACC_W'(prod_q);
  end

  // round to Q1.15 and saturate
  logic signed [ACC_W-1:0] rnd_s;
  logic signed [SMP_W-1:0] dot_d, dot_q;
  always_comb begin
    rnd_s = (acc_q + ACC_W'(65536)) >>> 17;
    if (rnd_s > ACC_W'(32767))       dot_d = 16'sh7FFF;
    else if (rnd_s < -ACC_W'(32768)) dot_d = 16'sh8000;
    else                             dot_d = rnd_s[SMP_W-1:0];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) dot_q <= dot_d;
  end

  // loop state
  logic signed [31:0] phase_q, freq_q;
  logic signed [SMP_W-1:0] prev_q, mid_q;
  logic slot_q;
  logic signed [32:0] err_q;
  logic signed [57:0] pa_q, pb_q;
  logic signed [31:0] at_q;
  logic signed [32:0] bt_q;

  logic signed [32:0] psum;
  logic signed [31:0] psat;
  logic signed [SMP_W:0] diff;
  logic opp;
  logic signed [57:0] ra, rb;
  logic signed [34:0] dev, devc, mfd_s;
  logic signed [33:0] pcor;
  logic signed [31:0] pcor_sat;

  always_comb begin
    psum = 33'(phase_q) + 33'(freq_q);
    if (psum > 33'sh0_7FFF_FFFF)       psat = 32'sh7FFF_FFFF;
    else if (psum < -33'sh0_8000_0000) psat = 32'sh8000_0000;
    else                               psat = psum[31:0];
    opp  = (dot_q < 0 && prev_q > 0) || (dot_q > 0 && prev_q < 0);
    diff = 17'(dot_q) - 17'(prev_q);
    ra = (pa_q + 58'sd16777216) >>> 25;
    rb = (pb_q + 58'sd16777216) >>> 25;
    mfd_s = 35'($signed({1'b0, mfd_q}));
    dev   = 35'(phase_q) - 35'($signed({1'b0, ctr_q})) + 35'(bt_q);
    if (dev > mfd_s)       devc = mfd_s;
    else if (dev < -mfd_s) devc = -mfd_s;
    else                   devc = dev;
    pcor = 34'(phase_q) - (34'(Q29_TWO) - 34'(at_q));
    if (pcor > 34'sh0_7FFF_FFFF)       pcor_sat = 32'sh7FFF_FFFF;
    else if (pcor < -34'sh0_8000_0000) pcor_sat = 32'sh8000_0000;
    else                               pcor_sat = pcor[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      freq_q  <= $signed({2'b00, CENTER_RST});
      prev_q  <= '0;
      mid_q   <= '0;
      slot_q  <= 1'b0;
    end else begin
      if (cmd_i.add) phase_q <= psat;
      if (cmd_i.mid_ld) begin
        mid_q  <= dot_q;
        slot_q <= 1'b1;
      end
      if (cmd_i.err) begin
        prev_q <= dot_q;
        slot_q <= 1'b0;
      end
      if (cmd_i.upd) begin
        phase_q <= pcor_sat;
        freq_q  <= 32'($signed({1'b0, ctr_q})) + devc[31:0];
      end
    end
  end

  // error, gain products, rounded terms
  always_ff @(posedge clk_i) begin
    if (cmd_i.err)  err_q <= opp ? 33'(diff * mid_q) : '0;
    if (cmd_i.gain) begin
      pa_q <= err_q * $signed({1'b0, pg_q});
      pb_q <= err_q * $signed({1'b0, fg_q});
    end
    if (cmd_i.trm) begin
      if (ra > 58'(Q29_TWO))       at_q <= Q29_TWO;
      else if (ra < -58'(Q29_TWO)) at_q <= -Q29_TWO;
      else                         at_q <= ra[31:0];
      bt_q <= rb[32:0];
    end
  end

  // symbol hold and output register
  logic signed [SMP_W-1:0] hold_q;
  logic hold_v_q, out_v_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_ld) hold_q <= dot_q;
    if (cmd_i.push) begin
      out_sym_o  <= hold_q;
      out_last_o <= cmd_i.last;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.hold_ld) hold_v_q <= 1'b1;
      else if (cmd_i.push && cmd_i.last) hold_v_q <= 1'b0;
      if (cmd_i.push) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_v_q;
  assign sts_o.hit       = phase_q >= (slot_q ? Q29_TWO : Q29_ONE);
  assign sts_o.slot      = slot_q;
  assign sts_o.out_free  = !out_v_q || out_ready_i;
  assign sts_o.hold_v    = hold_v_q;

endmodule

/* src/gsr_ctrl.sv */
// Controller: sequences sub-steps, the tap loop, the loop update and symbol delivery.
// Depends on gsr_pkg; drives gsr_datapath.
module gsr_ctrl import gsr_pkg::*; #(
  parameter int TAPS   = TAPS_DEF,
  parameter int PHASES = PHASES_DEF,
  localparam int BW    = (PHASES > 1) ? $clog2(PHASES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  output logic          in_ready_o,
  input  gsr_sts_t      sts_i,
  output gsr_cmd_t      cmd_o,
  output logic [BW-1:0] bank_o
);

  localparam int CW = $clog2(TAPS + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_DOT  = 4'd3;
  localparam logic [3:0] S_RND  = 4'd4;
  localparam logic [3:0] S_SORT = 4'd5;
  localparam logic [3:0] S_GAIN = 4'd6;
  localparam logic [3:0] S_TRM  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_PUSH = 4'd9;
  localparam logic [3:0] S_NEXT = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [BW-1:0] step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign bank_o     = BW'(PHASES - 1) - step_q;
  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i) cmd_o.coef_wr = 1'b1;
          else begin
            cmd_o.line_wr = 1'b1;
            step_d  = '0;
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.clr = 1'b1;
          cnt_d     = '0;
          state_d   = S_DOT;
        end else state_d = S_NEXT;
      end
      S_DOT: begin
        cmd_o.rd  = cnt_q < CW'(TAPS);
        cmd_o.mul = (cnt_q >= CW'(1)) && (cnt_q <= CW'(TAPS));
        cmd_o.acc = cnt_q >= CW'(2);
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(TAPS + 1)) state_d = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_SORT;
      end
      S_SORT: begin
        if (!sts_i.slot) begin
          cmd_o.mid_ld = 1'b1;
          state_d      = S_NEXT;
        end else begin
          cmd_o.err = 1'b1;
          state_d   = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = S_TRM;
      end
      S_TRM: begin
        cmd_o.trm = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_PUSH;
      end
      // release the held symbol as not last, then hold the new one
      S_PUSH: begin
        if (!sts_i.hold_v) begin
          cmd_o.hold_ld = 1'b1;
          state_d       = S_NEXT;
        end else if (sts_i.out_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.hold_ld = 1'b1;
          state_d       = S_NEXT;
        end
      end
      S_NEXT: begin
        if (step_q == BW'(PHASES - 1)) state_d = S_FIN;
        else begin
          step_d  = step_q + 1'b1;
          state_d = S_ADD;
        end
      end
      // release the final symbol of this sample as last
      S_FIN: begin
        if (!sts_i.hold_v) state_d = S_IDLE;
        else if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* src/gardner_symbol_timing_recovery_top.sv */
// Channel | dir | payload                                    | transfer
// smp_i   | in  | func, sample_value, coeff_index, coeff_value | valid & ready
// sym_o   | out | symbol_value, last_of_run                  | valid & ready
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i            | write on cfg_we_i
// A coefficient transaction leaves the block idle and ready for the next item. A sample
// transaction keeps it busy through every phase step, and longer for each mid-point or symbol hit,
// as the single shared MAC walks the taps.
// Reset clears the delay line and loop state; coefficients must be loaded before use.
// The output register holds a symbol while sym_o stalls; the block stalls at the next symbol.
// Top level: joins gsr_ctrl and gsr_datapath; depends on gsr_pkg and gsr_if.
module gardner_symbol_timing_recovery_top import gsr_pkg::*; #(
  parameter int TAPS   = TAPS_DEF,
  parameter int PHASES = PHASES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gsr_in_if.sink                smp_i,
  gsr_out_if.source             sym_o
);

  localparam int BW = (PHASES > 1) ? $clog2(PHASES) : 1;

  gsr_cmd_t      cmd;
  gsr_sts_t      sts;
  logic [BW-1:0] bank;

  gsr_ctrl #(.TAPS(TAPS), .PHASES(PHASES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_func_i  (smp_i.func),
    .in_ready_o (smp_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .bank_o     (bank)
  );

  gsr_datapath #(.TAPS(TAPS), .PHASES(PHASES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (smp_i.sample_value),
    .cidx_i      (smp_i.coeff_index),
    .cval_i      (smp_i.coeff_value),
    .bank_i      (bank),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (sym_o.ready),
    .out_valid_o (sym_o.valid),
    .out_sym_o   (sym_o.symbol_value),
    .out_last_o  (sym_o.last_of_run)
  );

endmodule

/* src/gsr_checker.sv */
// Port-level checks for the timing recovery top level, attached by bind.
// Depends on gsr_pkg and the top level's ports.
module gsr_checker import gsr_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_func,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SMP_W-1:0] out_sym,
  input logic                    out_last
);

  // a sample transaction starts work: no new transaction next cycle
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !in_func |=> !in_ready)
    else $error("input taken right after a sample");

  // a coefficient load never produces a symbol
  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_func |=> !$rose(out_valid))
    else $error("symbol after coefficient load");

  // new symbols appear only while a sample is in work
  a_sym_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("symbol appeared while idle");

  // stalled symbol holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_sym) && $stable(out_last))
    else $error("stalled symbol changed");

endmodule

bind gardner_symbol_timing_recovery_top gsr_checker u_gsr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (smp_i.valid),
  .in_ready  (smp_i.ready),
  .in_func   (smp_i.func),
  .out_valid (sym_o.valid),
  .out_ready (sym_o.ready),
  .out_sym   (sym_o.symbol_value),
  .out_last  (sym_o.last_of_run)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for gardner_symbol_timing_recovery_top: drives random sample and
// coefficient transactions, predicts the recovered symbols and checks them in order.
// Depends on gsr_pkg, gsr_if and the top level RTL.
module testbench;
  import gsr_pkg::*;

  localparam int TAPS    = TAPS_DEF;
  localparam int PHASES  = PHASES_DEF;
  localparam int NCOEF   = TAPS * PHASES;
  localparam longint ONE_Q29 = 64'sd1 << 29;
  localparam longint TWO_Q29 = 64'sd1 << 30;
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct {
    logic signed [SMP_W-1:0] value;
    logic                    last;
  } symbol_t;

  // Timing loop predictor with an ordered store of expected symbols
  class symbol_scoreboard;
    longint center, maxdev, pgain, fgain;
    longint phase, freq, prev_sym, mid;
    logic signed [SMP_W-1:0]  line [TAPS];
    logic signed [COEF_W-1:0] coef [NCOEF];
    int      wpos;
    bit      slot;
    int      errors;
    symbol_t expected_syms[$];

    function new();
      center = CENTER_RST; maxdev = MAXDEV_RST; pgain = PGAIN_RST; fgain = FGAIN_RST;
      foreach (line[i]) line[i] = '0;
      foreach (coef[i]) coef[i] = '0;
      wpos = 0; phase = 0; freq = center; slot = 0; prev_sym = 0; mid = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER: center = data[29:0];
        CFG_MAXDEV: maxdev = data[28:0];
        CFG_PGAIN:  pgain  = data[23:0];
        CFG_FGAIN:  fgain  = data[23:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat32(longint v);
      return clamp(v, -(64'sd1 << 31), (64'sd1 << 31) - 1);
    endfunction

    // Walk the delay line oldest first against one coefficient bank
    function longint interp(int bank);
      longint acc;
      int p;
      acc = 0;
      p = wpos;
      for (int k = 0; k < TAPS; k++) begin
        acc += longint'(line[p]) * longint'(coef[bank * TAPS + k]);
        p = (p + 1 >= TAPS) ? 0 : p + 1;
      end
      return clamp((acc + (64'sd1 << 16)) >>> 17, -32768, 32767);
    endfunction

    // Apply one accepted transaction and queue the symbols it causes
    function void note(logic func, logic signed [SMP_W-1:0] smp,
                       logic [CIDX_W-1:0] ci, logic signed [COEF_W-1:0] cv);
      longint sym, err, a_term, b_term, dev;
      int n;
      symbol_t s;
      n = 0;
      if (func == FUNC_COEF) begin
        if (ci < NCOEF) coef[ci] = cv;
        return;
      end
      line[wpos] = smp;
      wpos = (wpos + 1 >= TAPS) ? 0 : wpos + 1;
      for (int step = 0; step < PHASES; step++) begin
        phase = sat32(phase + freq);
        if (phase < (slot ? TWO_Q29 : ONE_Q29)) continue;
        if (!slot) begin
          mid  = interp(PHASES - 1 - step);
          slot = 1;
        end else begin
          sym  = interp(PHASES - 1 - step);
          slot = 0;
          err  = 0;
          if ((sym < 0 && prev_sym > 0) || (sym > 0 && prev_sym < 0))
            err = (sym - prev_sym) * mid;
          prev_sym = sym;
          a_term = clamp((err * pgain + (64'sd1 << 24)) >>> 25, -TWO_Q29, TWO_Q29);
          b_term = (err * fgain + (64'sd1 << 24)) >>> 25;
          dev    = phase - center + b_term;
          phase  = sat32(phase - (TWO_Q29 - a_term));
          dev    = clamp(dev, -maxdev, maxdev);
          freq   = center + dev;
          s.value = sym[15:0];
          s.last  = 1'b0;
          expected_syms.push_back(s);
          n++;
        end
      end
      if (n > 0) expected_syms[$].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic signed [SMP_W-1:0] value, logic last);
      symbol_t e;
      if (expected_syms.size() == 0) begin
        report($sformatf("unexpected symbol %0d", value));
        return;
      end
      e = expected_syms.pop_front();
      if (value !== e.value)
        report($sformatf("symbol_value got %0d want %0d", value, e.value));
      if (last !== e.last)
        report($sformatf("last_of_run got %0b want %0b", last, e.last));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gsr_in_if  smp ();
  gsr_out_if sym ();

  gardner_symbol_timing_recovery_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp),
    .sym_o      (sym)
  );

  symbol_scoreboard sb = new();
  int burst_left = 0;
  int stall_left = 0;
  bit stall_mode = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: alternate between quiet stretches and random stall bursts
  initial sym.ready = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      sym.ready = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      if (stall_left > 0) begin
        sym.ready = 1'b0;
        stall_left--;
      end else if (stall_mode && $urandom_range(0, 9) < 3) begin
        sym.ready  = 1'b0;
        stall_left = $urandom_range(0, 40);
      end else begin
        sym.ready = 1'b1;
      end
    end
  end

  // Check each symbol transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && sym.valid && sym.ready)
      sb.check(sym.symbol_value, sym.last_of_run);
  end

  // Drive one transaction in bursts with random gaps; starts and ends on a falling edge
  task automatic send_item(logic func, logic signed [SMP_W-1:0] s,
                           logic [CIDX_W-1:0] ci, logic signed [COEF_W-1:0] cv);
    int gap;
    if (burst_left == 0) begin
      smp.valid = 1'b0;
      gap = $urandom_range(1, 30);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    smp.valid        = 1'b1;
    smp.func         = func;
    smp.sample_value = s;
    smp.coeff_index  = ci;
    smp.coeff_value  = cv;
    do @(posedge clk_i); while (!smp.ready);
    sb.note(func, s, ci, cv);
    @(negedge clk_i);
    smp.valid = 1'b0;
  endtask

  task automatic send_sample(logic signed [SMP_W-1:0] s);
    send_item(FUNC_SAMPLE, s, CIDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(logic [CIDX_W-1:0] ci, logic signed [COEF_W-1:0] cv);
    send_item(FUNC_COEF, SMP_W'($urandom), ci, cv);
  endtask

  // Hold the sender until every expected symbol is back, then let the block settle
  task automatic drain();
    smp.valid = 1'b0;
    while (sb.expected_syms.size() > 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic set_loop(logic [29:0] c, logic [28:0] m, logic [23:0] p, logic [23:0] f);
    write_reg(CFG_CENTER, CFG_DATA_W'(c));
    write_reg(CFG_MAXDEV, CFG_DATA_W'(m));
    write_reg(CFG_PGAIN,  CFG_DATA_W'(p));
    write_reg(CFG_FGAIN,  CFG_DATA_W'(f));
  endtask

  // Mostly large alternating-sign samples so the error term stays busy
  task automatic random_samples(int count);
    logic signed [SMP_W-1:0] s;
    bit pos;
    pos = 1'b0;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    s = SMP_W'($urandom);
        2:       s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        3:       s = SMP_W'($urandom_range(0, 6)) - 16'sd3;
        default: begin
          if ($urandom_range(0, 3) != 0) pos = ~pos;
          s = pos ? SMP_W'($urandom_range(4000, 32767))
                  : -SMP_W'($urandom_range(4000, 32768));
        end
      endcase
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) send_coef(CIDX_W'($urandom_range(0, NCOEF - 1)),
                                            COEF_W'($urandom));
        else send_coef(CIDX_W'($urandom_range(NCOEF, 1023)), COEF_W'($urandom));
      end
      send_sample(s);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    smp.valid        = 1'b0;
    smp.func         = FUNC_SAMPLE;
    smp.sample_value = '0;
    smp.coeff_index  = '0;
    smp.coeff_value  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Load every coefficient before any sample reads the store
    for (int i = 0; i < NCOEF; i++) begin
      if (i == 0)      send_coef(CIDX_W'(i), 18'sh1ffff);
      else if (i == 1) send_coef(CIDX_W'(i), 18'sh20000);
      else             send_coef(CIDX_W'(i), COEF_W'($urandom_range(0, 65535)) - 18'sd32768);
    end
    // Ignored indexes: right past the store and the top of the range
    send_coef(CIDX_W'(NCOEF), 18'sh1ffff);
    send_coef(10'd1023, 18'sh20000);
    set_loop(CENTER_RST, MAXDEV_RST, PGAIN_RST, FGAIN_RST);

    // Directed: sample extremes with alternating signs
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(16'shffff);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    drain();

    // Change center alone: the running frequency keeps its value until a symbol
    write_reg(CFG_CENTER, CFG_DATA_W'(30'd134217728 + 30'd40000));
    random_samples(50);
    drain();

    // Extremes: fastest phase step and full gains drive the accumulator to saturation
    set_loop(30'h3fffffff, 29'h1fffffff, 24'hffffff, 24'hffffff);
    random_samples(45);
    drain();

    // Zero center and gains: frequency pinned at the deviation limit
    set_loop(30'd0, 29'd268435456, 24'd0, 24'd0);
    random_samples(40);
    drain();

    set_loop(30'd134230073, 29'd4194304, 24'd1048576, 24'd4096);
    random_samples(60);
    drain();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

endmodule
